// ===== rtl/rqs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqs_pkg
// Shared constants, types and the box union function for the quadratic node split.
// ----------------------------------------------------------------------------
package rqs_pkg;
    localparam int NODE_CAPACITY = 8;
    localparam int STORE_DEPTH   = NODE_CAPACITY + 1;
    localparam int IDX_BITS      = $clog2(STORE_DEPTH);
    localparam int CNT_BITS      = $clog2(STORE_DEPTH + 1);
    localparam int COORD_BITS    = 16;
    localparam int EXT_BITS      = COORD_BITS + 1;
    localparam int VOL_BITS      = 2 * EXT_BITS;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] lx;
        logic signed [COORD_BITS-1:0] hx;
        logic signed [COORD_BITS-1:0] ly;
        logic signed [COORD_BITS-1:0] hy;
    } box_t;

    function automatic box_t box_union(box_t p, box_t q);
        box_t u;
        u.lx = (p.lx < q.lx) ? p.lx : q.lx;
        u.hx = (p.hx > q.hx) ? p.hx : q.hx;
        u.ly = (p.ly < q.ly) ? p.ly : q.ly;
        u.hy = (p.hy > q.hy) ? p.hy : q.hy;
        return u;
    endfunction
endpackage

// ===== rtl/rtree_quadratic_node_split.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtree_quadratic_node_split
// Quadratic R-tree node split over up to nine stored 2-D rectangles.
// ----------------------------------------------------------------------------
// Rectangles load one word per cycle. The word with tlast set starts the
// split; s_tready then stays low until every result word has been taken.
// One shared volume unit (one multiply, registered) is reused for every area:
// the seed scan computes the volumes of each entry pair and of their union and
// compares the waste, and each pick computes the two group volumes, checks
// every stored entry, computes both union volumes for each unassigned entry
// and then places the pick. Result words follow, one per cycle while m_tready
// is high.
module rtree_quadratic_node_split
    import rqs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // low_x, high_x, low_y, high_y
    input  logic        s_tlast,   // final_entry
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // entry_index[5:0], group_id[6], zero
    output logic        m_tlast    // last_result
);
    localparam logic [3:0] ST_LOAD  = 4'd0;
    localparam logic [3:0] ST_SEEDA = 4'd1;  // vol of i
    localparam logic [3:0] ST_SEEDB = 4'd2;  // vol of j
    localparam logic [3:0] ST_SEEDC = 4'd3;  // vol of union
    localparam logic [3:0] ST_SEEDD = 4'd4;  // compare
    localparam logic [3:0] ST_GVA   = 4'd5;
    localparam logic [3:0] ST_GVB   = 4'd6;
    localparam logic [3:0] ST_GCHK  = 4'd7;
    localparam logic [3:0] ST_PUA   = 4'd8;
    localparam logic [3:0] ST_PUB   = 4'd9;
    localparam logic [3:0] ST_PCMP  = 4'd10;
    localparam logic [3:0] ST_PASG  = 4'd11;
    localparam logic [3:0] ST_FILL  = 4'd12;
    localparam logic [3:0] ST_OUT   = 4'd13;

    box_t store [STORE_DEPTH];
    logic [3:0] state_reg;
    logic [5:0] min_fill_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [STORE_DEPTH-1:0] asg_reg, grp_reg;
    logic [IDX_BITS-1:0] i_reg, j_reg, si_reg, sj_reg, pick_reg;
    logic have_reg, pgrp_reg, fgrp_reg;
    box_t ga_reg, gb_reg;
    logic [CNT_BITS-1:0] sa_reg, sb_reg, rem_reg;
    logic [VOL_BITS-1:0] vi_reg, vj_reg, va_reg, vb_reg, ea_reg, prod_reg;
    logic [VOL_BITS+1:0] bw_reg, best_reg;
    box_t mbox;
    logic signed [EXT_BITS-1:0] dx, dy;
    box_t in_box, bi, bj;

    // shared volume unit
    assign dx = EXT_BITS'(mbox.hx) - EXT_BITS'(mbox.lx);
    assign dy = EXT_BITS'(mbox.hy) - EXT_BITS'(mbox.ly);

    assign bi = store[i_reg];
    assign bj = store[j_reg];

    always_comb
    begin
        case (state_reg)
            ST_SEEDA: mbox = bi;
            ST_SEEDB: mbox = bj;
            ST_SEEDC: mbox = box_union(bi, bj);
            ST_GVA:   mbox = ga_reg;
            ST_GVB:   mbox = gb_reg;
            ST_PUA:   mbox = box_union(ga_reg, bi);
            ST_PUB:   mbox = box_union(gb_reg, bi);
            default:  mbox = bi;
        endcase
    end

    always_comb
    begin
        in_box.lx = s_tdata[15:0];
        in_box.hx = s_tdata[31:16];
        in_box.ly = s_tdata[47:32];
        in_box.hy = s_tdata[63:48];
        if (in_box.lx > in_box.hx)
        begin
            in_box.lx = s_tdata[31:16];
            in_box.hx = s_tdata[15:0];
        end
        if (in_box.ly > in_box.hy)
        begin
            in_box.ly = s_tdata[63:48];
            in_box.hy = s_tdata[47:32];
        end
    end

    logic s_acc;
    assign s_acc    = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {1'b0, grp_reg[i_reg], 6'(i_reg)};
    assign m_tlast  = (CNT_BITS'(i_reg) + 1'b1 == cnt_reg);

    // waste = (vu - vi) - vj  ; enlargement diff from ea/eb
    logic [VOL_BITS+1:0] waste, eb, d;
    logic gt_seed, fill0, fill1, last_i;
    assign waste = {2'b0, prod_reg} - {2'b0, vi_reg} - {2'b0, vj_reg};
    assign gt_seed = $signed(waste) > $signed(bw_reg);
    assign eb = {2'b0, prod_reg} - {2'b0, vb_reg};
    assign d = ({2'b0, ea_reg} > eb) ? {2'b0, ea_reg} - eb : eb - {2'b0, ea_reg};
    assign fill0 = 7'(sa_reg) + 7'(rem_reg) <= 7'(min_fill_reg);
    assign fill1 = 7'(sb_reg) + 7'(rem_reg) <= 7'(min_fill_reg);
    assign last_i = (CNT_BITS'(i_reg) + 1'b1 == cnt_reg);

    always_ff @(posedge clk)
    begin
        prod_reg <= VOL_BITS'(dx * dy);
        if (s_acc && cnt_reg < CNT_BITS'(STORE_DEPTH))
            store[cnt_reg[IDX_BITS-1:0]] <= in_box;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            min_fill_reg <= 6'd3;
            cnt_reg      <= '0;
            asg_reg      <= '0;
            grp_reg      <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            si_reg       <= '0;
            sj_reg       <= '0;
            pick_reg     <= '0;
            have_reg     <= 1'b0;
            pgrp_reg     <= 1'b0;
            fgrp_reg     <= 1'b0;
            sa_reg       <= '0;
            sb_reg       <= '0;
            rem_reg      <= '0;
            ga_reg       <= '0;
            gb_reg       <= '0;
            vi_reg       <= '0;
            vj_reg       <= '0;
            va_reg       <= '0;
            vb_reg       <= '0;
            ea_reg       <= '0;
            bw_reg       <= '0;
            best_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
                min_fill_reg <= cfg_wdata;
            case (state_reg)
                ST_LOAD:
                begin
                    if (s_acc)
                    begin
                        logic [CNT_BITS-1:0] n;
                        n = (cnt_reg < CNT_BITS'(STORE_DEPTH)) ? cnt_reg + 1'b1 : cnt_reg;
                        cnt_reg <= n;
                        asg_reg <= '0;
                        grp_reg <= '0;
                        if (s_tlast)
                        begin
                            i_reg    <= '0;
                            j_reg    <= IDX_BITS'(1);
                            have_reg <= 1'b0;
                            state_reg <= (n < CNT_BITS'(2)) ? ST_OUT : ST_SEEDA;
                        end
                    end
                end
                ST_SEEDA: state_reg <= ST_SEEDB;
                ST_SEEDB:
                begin
                    vi_reg    <= prod_reg;
                    state_reg <= ST_SEEDC;
                end
                ST_SEEDC:
                begin
                    vj_reg    <= prod_reg;
                    state_reg <= ST_SEEDD;
                end
                ST_SEEDD:
                begin
                    if (!have_reg || gt_seed)
                    begin
                        have_reg <= 1'b1;
                        bw_reg   <= waste;
                        si_reg   <= i_reg;
                        sj_reg   <= j_reg;
                    end
                    if (CNT_BITS'(j_reg) + 1'b1 < cnt_reg)
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_SEEDA;
                    end
                    else if (CNT_BITS'(i_reg) + CNT_BITS'(2) < cnt_reg)
                    begin
                        i_reg     <= i_reg + 1'b1;
                        j_reg     <= i_reg + IDX_BITS'(2);
                        state_reg <= ST_SEEDA;
                    end
                    else
                        state_reg <= ST_FILL;
                end
                ST_FILL:
                begin
                    // seed placement
                    asg_reg[si_reg] <= 1'b1;
                    asg_reg[sj_reg] <= 1'b1;
                    grp_reg[sj_reg] <= 1'b1;
                    ga_reg  <= store[si_reg];
                    gb_reg  <= store[sj_reg];
                    sa_reg  <= CNT_BITS'(1);
                    sb_reg  <= CNT_BITS'(1);
                    rem_reg <= cnt_reg - CNT_BITS'(2);
                    state_reg <= ST_GVA;
                end
                ST_GVA: state_reg <= ST_GVB;
                ST_GVB:
                begin
                    va_reg    <= prod_reg;
                    state_reg <= ST_GCHK;
                end
                ST_GCHK:
                begin
                    vb_reg   <= prod_reg;
                    i_reg    <= '0;
                    have_reg <= 1'b0;
                    if (rem_reg == '0)
                        state_reg <= ST_OUT;
                    else if (fill0 || fill1)
                    begin
                        fgrp_reg  <= !fill0;
                        state_reg <= ST_PASG;
                    end
                    else
                        state_reg <= ST_PUA;
                end
                ST_PUA:
                begin
                    if (asg_reg[i_reg])
                    begin
                        if (last_i)
                            state_reg <= ST_PASG;
                        else
                            i_reg <= i_reg + 1'b1;
                    end
                    else
                        state_reg <= ST_PUB;
                end
                ST_PUB:
                begin
                    ea_reg    <= prod_reg - va_reg;
                    state_reg <= ST_PCMP;
                end
                ST_PCMP:
                begin
                    if (!have_reg || d > best_reg)
                    begin
                        have_reg <= 1'b1;
                        best_reg <= d;
                        pick_reg <= i_reg;
                        if ({2'b0, ea_reg} != eb)
                            pgrp_reg <= !({2'b0, ea_reg} < eb);
                        else if (va_reg != vb_reg)
                            pgrp_reg <= !(va_reg < vb_reg);
                        else
                            pgrp_reg <= !(sa_reg < sb_reg);
                    end
                    if (last_i)
                        state_reg <= ST_PASG;
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_PUA;
                    end
                end
                ST_PASG:
                begin
                    if (fill0 || fill1)
                    begin
                        // hand all remaining entries to one group
                        for (int k = 0; k < STORE_DEPTH; k++)
                            if (CNT_BITS'(k) < cnt_reg && !asg_reg[k])
                            begin
                                asg_reg[k] <= 1'b1;
                                grp_reg[k] <= fgrp_reg;
                            end
                        i_reg     <= '0;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        asg_reg[pick_reg] <= 1'b1;
                        grp_reg[pick_reg] <= pgrp_reg;
                        rem_reg <= rem_reg - 1'b1;
                        if (pgrp_reg)
                        begin
                            gb_reg <= box_union(gb_reg, store[pick_reg]);
                            sb_reg <= sb_reg + 1'b1;
                        end
                        else
                        begin
                            ga_reg <= box_union(ga_reg, store[pick_reg]);
                            sa_reg <= sa_reg + 1'b1;
                        end
                        state_reg <= ST_GVA;
                    end
                end
                ST_OUT:
                begin
                    if (m_tready)
                    begin
                        if (last_i)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= ST_LOAD;
                        end
                        else
                            i_reg <= i_reg + 1'b1;
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end
endmodule

// ===== rtl/rqs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqs_checker
// Port-level checks for the quadratic node split.
// ----------------------------------------------------------------------------
module rqs_checker
    import rqs_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid)) else $error("input open while results pending");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid &&
        m_tdata[5:0] == $past(m_tdata[5:0]) + 6'd1)
        else $error("entry index out of order");
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("input not reopened after last result");
endmodule

bind rtree_quadratic_node_split rqs_checker u_rqs_checker (.*);
